// ===== hdl/lbccg_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and helper functions for the core count governor.
// No dependencies; every other file of the block imports this package.
package lbccg_pkg;

  localparam int CORE_COUNT = 8;
  localparam int INTERVAL_W = 16;  // default width of the elapsed counter
  localparam int UTIL_W     = 7;
  localparam int SUM_W      = 10;  // eight utilisations of at most 100
  localparam int CNT_W      = 4;   // online count, 0..8
  localparam int AVG_W      = 7;   // average fits in 7 bits, so 7 divide steps
  localparam int CORE_W     = 4;

  localparam logic [UTIL_W-1:0] UTIL_MAX = 7'd100;

  localparam logic [15:0]       RST_INTERVAL = 16'd500;
  localparam logic [6:0]        RST_UP       = 7'd98;
  localparam logic [6:0]        RST_DOWN     = 7'd49;
  localparam logic [CORE_W-1:0] RST_MAX      = CORE_W'(CORE_COUNT);
  localparam logic [CORE_W-1:0] RST_MIN      = 4'd5;

  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE         = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DYNAMIC_ENABLE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL_MS    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_UP_THRESHOLD   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DOWN_THRESHOLD = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_CORES      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_CORES      = 3'd6;
  localparam int CFG_DATA_W = 16;

  localparam logic MODE_TICK  = 1'b0;
  localparam logic MODE_EVENT = 1'b1;

  typedef struct packed {
    logic              mode;
    logic              display_on;
    logic [7:0]        online_mask;
    logic [UTIL_W-1:0] util_core0;
    logic [UTIL_W-1:0] util_core1;
    logic [UTIL_W-1:0] util_core2;
    logic [UTIL_W-1:0] util_core3;
    logic [UTIL_W-1:0] util_core4;
    logic [UTIL_W-1:0] util_core5;
    logic [UTIL_W-1:0] util_core6;
    logic [UTIL_W-1:0] util_core7;
  } in_item_t;

  typedef struct packed {
    logic [CORE_W-1:0] target_cores;
    logic [7:0]        core_mask;
    logic              apply_request;
    logic              evaluated;
    logic [AVG_W-1:0]  average_load;
  } out_item_t;

  typedef struct packed {
    logic              enable;
    logic              dynamic_enable;
    logic [15:0]       interval_ms;
    logic [6:0]        up_threshold;
    logic [6:0]        down_threshold;
    logic [CORE_W-1:0] max_cores;
    logic [CORE_W-1:0] min_cores;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_EVAL,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic capture;
    logic div_init;
    logic div_step;
    logic upd_plain;
    logic upd_eval;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic eval_go;
    logic out_free;
  } status_t;

  function automatic logic [CORE_W-1:0] limit_cores(input logic [CORE_W-1:0] v);
    logic [CORE_W-1:0] r;
    if (v == '0) begin
      r = CORE_W'(1);
    end else if (v > CORE_W'(CORE_COUNT)) begin
      r = CORE_W'(CORE_COUNT);
    end else begin
      r = v;
    end
    return r;
  endfunction

  // Big cores 4-7 fill first, then 0-3.
  function automatic logic [7:0] mask_for(input logic [CORE_W-1:0] n);
    logic [7:0] m;
    unique case (limit_cores(n))
      4'd1:    m = 8'h10;
      4'd2:    m = 8'h30;
      4'd3:    m = 8'h70;
      4'd4:    m = 8'hF0;
      4'd5:    m = 8'hF1;
      4'd6:    m = 8'hF3;
      4'd7:    m = 8'hF7;
      default: m = 8'hFF;
    endcase
    return m;
  endfunction

endpackage

// ===== hdl/load_based_core_count_governor_unit.sv =====
`timescale 1ns / 1ps
// Top level of the load based core count governor: configuration registers,
// sequencer and datapath. Depends on lbccg_pkg, lbccg_ctrl and lbccg_dp.
//
// One transaction in gives one transaction out. A millisecond tick, a load
// event with governing off and a load event inside the interval go through
// accept, check and output; an evaluating load event also runs the seven-step
// restoring divider that forms the average load from the summed utilisation
// and the online core count, then an evaluate step. Results wait in an output
// register, so a new transaction is accepted while the previous result is still
// stalled. Configuration writes are always ready; write only while idle.
module load_based_core_count_governor_unit #(
  parameter int INTERVAL_BITS = lbccg_pkg::INTERVAL_W
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // input channel
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  lbccg_pkg::in_item_t                   in_data,
  // result channel
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output lbccg_pkg::out_item_t                  out_data,
  // configuration write channel
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [lbccg_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [lbccg_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
  import lbccg_pkg::*;

  // Configuration registers.
  logic              enable_r, enable_nxt;
  logic              dyn_r, dyn_nxt;
  logic [15:0]       interval_r, interval_nxt;
  logic [6:0]        up_r, up_nxt;
  logic [6:0]        down_r, down_nxt;
  logic [CORE_W-1:0] max_r, max_nxt;
  logic [CORE_W-1:0] min_r, min_nxt;

  cfg_t    cfg;
  cmd_t    cmd;
  status_t status;

  // Always take writes; indexes beyond the register list are dropped.
  assign cfg_ready = 1'b1;

  always_comb begin
    enable_nxt   = enable_r;
    dyn_nxt      = dyn_r;
    interval_nxt = interval_r;
    up_nxt       = up_r;
    down_nxt     = down_r;
    max_nxt      = max_r;
    min_nxt      = min_r;
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_ENABLE:         enable_nxt   = cfg_wdata[0];
        CFG_DYNAMIC_ENABLE: dyn_nxt      = cfg_wdata[0];
        CFG_INTERVAL_MS:    interval_nxt = cfg_wdata[15:0];
        CFG_UP_THRESHOLD:   up_nxt       = cfg_wdata[6:0];
        CFG_DOWN_THRESHOLD: down_nxt     = cfg_wdata[6:0];
        CFG_MAX_CORES:      max_nxt      = cfg_wdata[CORE_W-1:0];
        CFG_MIN_CORES:      min_nxt      = cfg_wdata[CORE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r   <= 1'b0;
      dyn_r      <= 1'b0;
      interval_r <= RST_INTERVAL;
      up_r       <= RST_UP;
      down_r     <= RST_DOWN;
      max_r      <= RST_MAX;
      min_r      <= RST_MIN;
    end else begin
      enable_r   <= enable_nxt;
      dyn_r      <= dyn_nxt;
      interval_r <= interval_nxt;
      up_r       <= up_nxt;
      down_r     <= down_nxt;
      max_r      <= max_nxt;
      min_r      <= min_nxt;
    end
  end

  // Bundle the register file for the datapath.
  assign cfg.enable         = enable_r;
  assign cfg.dynamic_enable = dyn_r;
  assign cfg.interval_ms    = interval_r;
  assign cfg.up_threshold   = up_r;
  assign cfg.down_threshold = down_r;
  assign cfg.max_cores      = max_r;
  assign cfg.min_cores      = min_r;

  // Sequencer: hold the input stalled from acceptance until the result is
  // handed to the output register.
  lbccg_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // Datapath: sum, divide, advance the governor state and register the result.
  lbccg_dp #(
    .INTERVAL_BITS (INTERVAL_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg       (cfg),
    .cmd       (cmd),
    .status    (status),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

// ===== hdl/lbccg_ctrl.sv =====
`timescale 1ns / 1ps
// Sequencer for the core count governor: accept, check, divide, evaluate, output.
// Depends on lbccg_pkg; drives the datapath through cmd_t and reads status_t.
module lbccg_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  lbccg_pkg::status_t status,
  output lbccg_pkg::cmd_t   cmd
);
  import lbccg_pkg::*;

  localparam int STEP_W = $clog2(AVG_W);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(AVG_W - 1);

  state_t            state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    cmd       = '0;
    in_stall  = (state_r != ST_IDLE);
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (status.eval_go) begin
          cmd.div_init = 1'b1;
          step_nxt     = '0;
          state_nxt    = ST_DIV;
        end else begin
          cmd.upd_plain = 1'b1;
          state_nxt     = ST_OUT;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        step_nxt     = step_r + STEP_W'(1);
        if (step_r == LAST_STEP) begin
          state_nxt = ST_EVAL;
        end
      end
      ST_EVAL: begin
        cmd.upd_eval = 1'b1;
        state_nxt    = ST_OUT;
      end
      ST_OUT: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== hdl/lbccg_dp.sv =====
`timescale 1ns / 1ps
// Datapath of the core count governor: load sum, restoring divider, governor
// state and output register. Depends on lbccg_pkg; commanded by lbccg_ctrl.
module lbccg_dp #(
  parameter int INTERVAL_BITS = lbccg_pkg::INTERVAL_W
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  lbccg_pkg::in_item_t  in_data,
  input  lbccg_pkg::cfg_t      cfg,
  input  lbccg_pkg::cmd_t      cmd,
  output lbccg_pkg::status_t   status,
  input  logic                 out_stall,
  output logic                 out_valid,
  output lbccg_pkg::out_item_t out_data
);
  import lbccg_pkg::*;

  localparam int CMP_W = (INTERVAL_BITS > 16) ? INTERVAL_BITS : 16;

  // captured item
  logic                mode_r;
  logic                display_r;
  logic [SUM_W-1:0]    sum_r;
  logic [CNT_W-1:0]    count_r;

  // divider
  logic [CNT_W-1:0]    rem_r, rem_nxt;
  logic [AVG_W-1:0]    quo_r, quo_nxt;

  // governor state
  logic [CORE_W-1:0]        target_r, target_nxt;
  logic [INTERVAL_BITS-1:0] elapsed_r, elapsed_nxt;
  logic [AVG_W-1:0]         last_avg_r, last_avg_nxt;
  logic                     apply_r, apply_nxt;
  logic                     evald_r, evald_nxt;

  // output register
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_data_r, out_data_nxt;

  logic [UTIL_W-1:0] util [CORE_COUNT];
  logic [SUM_W-1:0]  sum_c;
  logic [CNT_W-1:0]  count_c;
  logic [CORE_W-1:0] eff_max, eff_min, shown, t_up, t_dn, t_new;
  logic [AVG_W-1:0]  avg;
  logic [CNT_W-1:0]  trial;
  logic              gov_on, interval_ok;

  assign util[0] = in_data.util_core0;
  assign util[1] = in_data.util_core1;
  assign util[2] = in_data.util_core2;
  assign util[3] = in_data.util_core3;
  assign util[4] = in_data.util_core4;
  assign util[5] = in_data.util_core5;
  assign util[6] = in_data.util_core6;
  assign util[7] = in_data.util_core7;

  // Clamp each utilisation to 100 and add up the online cores.
  always_comb begin
    sum_c   = '0;
    count_c = '0;
    for (int i = 0; i < CORE_COUNT; i++) begin
      if (in_data.online_mask[i]) begin
        sum_c   = sum_c + SUM_W'((util[i] > UTIL_MAX) ? UTIL_MAX : util[i]);
        count_c = count_c + CNT_W'(1);
      end
    end
  end

  assign eff_max     = limit_cores(cfg.max_cores);
  assign eff_min     = limit_cores(cfg.min_cores);
  assign gov_on      = cfg.enable && cfg.dynamic_enable && display_r;
  assign interval_ok = CMP_W'(elapsed_r) >= CMP_W'(cfg.interval_ms);

  assign status.eval_go  = (mode_r == MODE_EVENT) && gov_on && interval_ok;
  assign status.out_free = !out_valid_r || !out_stall;

  // One quotient bit a step; the remainder stays below the divisor.
  assign trial = {rem_r[CNT_W-2:0], quo_r[AVG_W-1]};

  always_comb begin
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    if (cmd.div_init) begin
      rem_nxt = CNT_W'(sum_r[SUM_W-1:AVG_W]);
      quo_nxt = sum_r[AVG_W-1:0];
    end else if (cmd.div_step) begin
      if (trial >= count_r) begin
        rem_nxt = trial - count_r;
        quo_nxt = {quo_r[AVG_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial;
        quo_nxt = {quo_r[AVG_W-2:0], 1'b0};
      end
    end
  end

  // An empty online mask averages to zero.
  assign avg  = (count_r == '0) ? '0 : quo_r;
  assign t_up = (target_r + CORE_W'(1) > eff_max) ? eff_max : target_r + CORE_W'(1);
  assign t_dn = (target_r - CORE_W'(1) < eff_min || target_r == '0) ?
                eff_min : target_r - CORE_W'(1);

  always_comb begin
    if (avg >= cfg.up_threshold) begin
      t_new = limit_cores(t_up);
    end else if (avg <= cfg.down_threshold) begin
      t_new = limit_cores(t_dn);
    end else begin
      t_new = limit_cores(target_r);
    end
  end

  always_comb begin
    target_nxt   = target_r;
    elapsed_nxt  = elapsed_r;
    last_avg_nxt = last_avg_r;
    apply_nxt    = apply_r;
    evald_nxt    = evald_r;
    if (cmd.upd_plain) begin
      apply_nxt = 1'b0;
      evald_nxt = 1'b0;
      if (mode_r == MODE_TICK) begin
        if (elapsed_r != '1) begin
          elapsed_nxt = elapsed_r + INTERVAL_BITS'(1);
        end
      end else if (!gov_on) begin
        target_nxt  = eff_max;
        elapsed_nxt = '0;
      end
    end else if (cmd.upd_eval) begin
      target_nxt   = t_new;
      elapsed_nxt  = '0;
      last_avg_nxt = avg;
      apply_nxt    = (count_r != t_new);
      evald_nxt    = 1'b1;
    end
  end

  assign shown = cfg.dynamic_enable ? limit_cores(target_r) : eff_max;

  always_comb begin
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt              = 1'b1;
      out_data_nxt.target_cores  = shown;
      out_data_nxt.core_mask     = mask_for(shown);
      out_data_nxt.apply_request = apply_r;
      out_data_nxt.evaluated     = evald_r;
      out_data_nxt.average_load  = last_avg_r;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r    <= RST_MAX;
      elapsed_r   <= '1;
      last_avg_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      target_r    <= target_nxt;
      elapsed_r   <= elapsed_nxt;
      last_avg_r  <= last_avg_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mode_r    <= in_data.mode;
      display_r <= in_data.display_on;
      sum_r     <= sum_c;
      count_r   <= count_c;
    end
    rem_r      <= rem_nxt;
    quo_r      <= quo_nxt;
    apply_r    <= apply_nxt;
    evald_r    <= evald_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking bench for load_based_core_count_governor_unit: random ticks and load events,
// a built-in model of the governor and an in-order result scoreboard.
// Depends on lbccg_pkg and the governor RTL only.
module tb_top;
  import lbccg_pkg::*;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  in_item_t              in_data   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_item_t             out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // Idling knobs, changed only between phases while the block is quiet
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  // Long receiver hold-off: the sequencer bumps the request count, the receiver counts it out
  int pause_asked = 0;
  int pause_seen  = 0;
  int pause_left  = 0;
  int total_items = 0;

  // ---------------------------------------------------------------------------
  // Governor model and the queue of results it still owes
  // ---------------------------------------------------------------------------
  class governor_scoreboard;
    cfg_t       regs;
    logic [3:0] target;
    logic [INTERVAL_W-1:0] elapsed;
    logic [6:0] last_avg;
    out_item_t  owed_q[$];
    int         fails;

    function new();
      regs.enable         = 1'b0;
      regs.dynamic_enable = 1'b0;
      regs.interval_ms    = RST_INTERVAL;
      regs.up_threshold   = RST_UP;
      regs.down_threshold = RST_DOWN;
      regs.max_cores      = RST_MAX;
      regs.min_cores      = RST_MIN;
      target   = 4'(CORE_COUNT);
      elapsed  = '1;
      last_avg = '0;
      fails    = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
      case (idx)
        CFG_ENABLE:         regs.enable         = d[0];
        CFG_DYNAMIC_ENABLE: regs.dynamic_enable = d[0];
        CFG_INTERVAL_MS:    regs.interval_ms    = d[15:0];
        CFG_UP_THRESHOLD:   regs.up_threshold   = d[6:0];
        CFG_DOWN_THRESHOLD: regs.down_threshold = d[6:0];
        CFG_MAX_CORES:      regs.max_cores      = d[3:0];
        CFG_MIN_CORES:      regs.min_cores      = d[3:0];
        default: ;
      endcase
    endfunction

    // Core limits of 0 act as one core, anything above the cluster size as all of it
    function logic [3:0] clip_cores(int v);
      if (v < 1) return 4'd1;
      if (v > CORE_COUNT) return 4'(CORE_COUNT);
      return v[3:0];
    endfunction

    // Big cores 4-7 come up first, then the little ones 0-3
    function logic [7:0] cores_to_mask(logic [3:0] n);
      logic [7:0] m;
      int k;
      m = '0;
      for (k = 0; k < int'(n); k++) m[(k < 4) ? k + 4 : k - 4] = 1'b1;
      return m;
    endfunction

    function void note_input(in_item_t it);
      logic [6:0] u [8];
      logic [3:0] eff_max, eff_min, shown;
      int         sum, cnt, avg, t, i;
      out_item_t  want;
      u = '{it.util_core0, it.util_core1, it.util_core2, it.util_core3,
            it.util_core4, it.util_core5, it.util_core6, it.util_core7};
      eff_max = clip_cores(regs.max_cores);
      eff_min = clip_cores(regs.min_cores);
      want    = '0;
      if (it.mode == MODE_TICK) begin
        if (elapsed != '1) elapsed++;
      end else if (!regs.enable || !regs.dynamic_enable || !it.display_on) begin
        // governing off: fall back to the max and restart the interval
        target  = eff_max;
        elapsed = '0;
      end else if (elapsed >= regs.interval_ms) begin
        elapsed = '0;
        want.evaluated = 1'b1;
        sum = 0;
        cnt = 0;
        avg = 0;
        for (i = 0; i < CORE_COUNT; i++) begin
          if (it.online_mask[i]) begin
            sum += (u[i] > 7'd100) ? 100 : int'(u[i]);
            cnt++;
          end
        end
        if (cnt != 0) avg = sum / cnt;
        t = target;
        // up test wins over down test; min above max is deliberately left alone
        if (avg >= int'(regs.up_threshold)) begin
          t++;
          if (t > int'(eff_max)) t = eff_max;
        end else if (avg <= int'(regs.down_threshold)) begin
          if (t > 0) t--;
          if (t < int'(eff_min)) t = eff_min;
        end
        target   = clip_cores(t);
        last_avg = avg[6:0];
        want.apply_request = (cnt != int'(target));
      end
      shown = regs.dynamic_enable ? clip_cores(target) : eff_max;
      want.target_cores = shown;
      want.core_mask    = cores_to_mask(shown);
      want.average_load = last_avg;
      owed_q.push_back(want);
    endfunction

    function void compare(string field, logic [7:0] w, logic [7:0] g);
      if (g !== w) begin
        $error("%s mismatch: expected %0d, actual %0d", field, w, g);
        fails++;
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (owed_q.size() == 0) begin
        $error("result with no transaction outstanding: %h", got);
        fails++;
        return;
      end
      want = owed_q.pop_front();
      compare("target_cores",  8'(want.target_cores),  8'(got.target_cores));
      compare("core_mask",     want.core_mask,         got.core_mask);
      compare("apply_request", 8'(want.apply_request), 8'(got.apply_request));
      compare("evaluated",     8'(want.evaluated),     8'(got.evaluated));
      compare("average_load",  8'(want.average_load),  8'(got.average_load));
    endfunction

    function int pending();
      return owed_q.size();
    endfunction
  endclass

  governor_scoreboard sb;

  load_based_core_count_governor_unit uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Receiver: random stalls, or a long hold-off when one is requested so the block backs up
  always @(posedge clk) begin
    if (pause_seen != pause_asked) begin
      pause_seen <= pause_asked;
      pause_left <= 80;
      out_stall  <= 1'b1;
    end else if (pause_left > 0) begin
      pause_left <= pause_left - 1;
      out_stall  <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Check every result transaction at the edge that accepts it
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  // kind 0: nothing online, kind 1: every core online and pinned above 100 %, else random
  function automatic in_item_t make_event(int kind);
    in_item_t   it;
    logic [6:0] u [8];
    int         level, j, i, r;
    bit         wild;
    level = $urandom_range(0, 100);
    wild  = ($urandom_range(3) == 0);
    for (i = 0; i < 8; i++) begin
      j = level + $urandom_range(0, 20) - 10;
      if (j < 0) j = 0;
      if (j > 100) j = 100;
      u[i] = wild ? 7'($urandom_range(0, 127)) : 7'(j);
    end
    it.mode       = MODE_EVENT;
    it.display_on = ($urandom_range(9) != 0);
    r = $urandom_range(7);
    if (kind == 0) begin
      it.online_mask = 8'h00;
    end else if (kind == 1) begin
      it.online_mask = 8'hFF;
      for (i = 0; i < 8; i++) u[i] = 7'h7F;
    end else begin
      it.online_mask = (r == 0) ? 8'h00 : (r == 1) ? 8'hFF : 8'($urandom);
    end
    it.util_core0 = u[0];
    it.util_core1 = u[1];
    it.util_core2 = u[2];
    it.util_core3 = u[3];
    it.util_core4 = u[4];
    it.util_core5 = u[5];
    it.util_core6 = u[6];
    it.util_core7 = u[7];
    return it;
  endfunction

  function automatic in_item_t make_tick();
    in_item_t it;
    it      = make_event(2);
    it.mode = MODE_TICK;
    return it;
  endfunction

  function automatic in_item_t make_noise();
    in_item_t it;
    it            = make_event(2);
    it.mode       = 1'($urandom_range(1));
    it.display_on = 1'($urandom_range(1));
    return it;
  endfunction

  // Mostly legal core limits, now and then zero or far above the cluster size
  function automatic int pick_cores();
    int r;
    r = $urandom_range(15);
    if (r == 0) return 0;
    if (r == 1) return 15;
    return $urandom_range(1, CORE_COUNT);
  endfunction

  // Offer one transaction; hold it until the block takes it
  task automatic send_item(in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    sb.note_input(it);
    total_items++;
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val[15:0];
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, val[15:0]);
  endtask

  task automatic set_config(bit en, bit dyn, int ivl, int up, int dn, int mx, int mn);
    write_reg(CFG_ENABLE,         en);
    write_reg(CFG_DYNAMIC_ENABLE, dyn);
    write_reg(CFG_INTERVAL_MS,    ivl);
    write_reg(CFG_UP_THRESHOLD,   up);
    write_reg(CFG_DOWN_THRESHOLD, dn);
    write_reg(CFG_MAX_CORES,      mx);
    write_reg(CFG_MIN_CORES,      mn);
    cfg_valid <= 1'b0;
  endtask

  // Drain: wait for every owed result, then let the sequencer fall back to idle
  task automatic settle();
    int guard;
    in_valid <= 1'b0;
    guard = 0;
    while (sb.pending() != 0 && guard < 5000) begin
      @(posedge clk);
      guard++;
    end
    repeat (16) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  initial begin
    in_item_t d;
    int       phase, ivl, up, dn, mx, mn, n, lo, seq, start_items;
    bit       en, dyn, can_eval, done;

    sb = new();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed opening. The elapsed counter leaves reset saturated, so the first load
    // event evaluates even against the longest interval.
    set_config(1'b1, 1'b1, 65535, 100, 0, 8, 1);
    d = '0;
    d.mode = MODE_TICK;
    send_item(d);                 // tick on a saturated counter: no wrap
    d = '1;
    send_item(d);                 // all cores at 127 %: read as 100 %, raise held at max
    d.mode = MODE_TICK;
    send_item(d);
    d = '1;
    send_item(d);                 // interval not yet passed
    d = '0;
    d.mode = MODE_EVENT;
    send_item(d);                 // display off: governing off, interval restarts
    d.display_on = 1'b1;
    send_item(d);                 // empty mask, inside the interval
    settle();

    // Mostly short intervals keep evaluations frequent within the item budget
    done  = 1'b0;
    phase = 1;
    while (!done) begin
      case (phase)
        1: begin en = 1; dyn = 1; ivl = 200; up = 98;  dn = 49;  mx = 8;  mn = 5; end
        2: begin en = 1; dyn = 1; ivl = 4;   up = 60;  dn = 40;  mx = 6;  mn = 2; end
        3: begin en = 1; dyn = 1; ivl = 7;   up = 100; dn = 100; mx = 15; mn = 0; end
        4: begin en = 1; dyn = 1; ivl = 0;   up = 0;   dn = 100; mx = 0;  mn = 15; end
        5: begin en = 1; dyn = 1; ivl = 2;   up = 100; dn = 100; mx = 3;  mn = 7; end
        6: begin en = 0; dyn = 1; ivl = 200; up = 50;  dn = 20;  mx = 4;  mn = 2; end
        7: begin en = 1; dyn = 0; ivl = 200; up = 50;  dn = 20;  mx = 5;  mn = 1; end
        default: begin
          en  = ($urandom_range(7) != 0);
          dyn = ($urandom_range(7) != 0);
          ivl = ($urandom_range(3) == 0) ? $urandom_range(200, 210) : $urandom_range(0, 8);
          up  = $urandom_range(0, 100);
          dn  = $urandom_range(0, 100);
          mx  = pick_cores();
          mn  = pick_cores();
        end
      endcase
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 87; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 87; end
        default: begin send_idle_pct = 27; recv_stall_pct = 27; end
      endcase
      set_config(en, dyn, ivl, up, dn, mx, mn);
      // hold the receiver off for a long stretch while items keep coming
      if (phase == 1) pause_asked <= pause_asked + 1;

      can_eval    = en && dyn;
      start_items = total_items;
      seq         = 0;
      while (total_items - start_items < 150) begin
        if (seq >= 2 && $urandom_range(99) < 15) begin
          // broken sequence: stray events and ticks at random
          repeat ($urandom_range(1, 5)) send_item(make_noise());
        end else begin
          // well-formed: wait out about one interval, then report load
          lo = (ivl > 0) ? ivl - 1 : 0;
          n  = can_eval ? $urandom_range(lo, ivl + 4) : $urandom_range(0, 30);
          repeat (n) send_item(make_tick());
          send_item(make_event((seq < 2) ? seq : 2));
        end
        seq++;
      end
      settle();
      phase++;
      done = (phase > 8 && total_items >= 1550);
    end

    if (sb.pending() != 0) $error("%0d results never arrived", sb.pending());
    if (sb.fails == 0 && sb.pending() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #8_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/lbccg_pkg.sv
hdl/lbccg_ctrl.sv
hdl/lbccg_dp.sv
hdl/load_based_core_count_governor_unit.sv
dv/tb_top.sv
